// ===== hw/rtl/cpxseg_pkg.sv =====
// Shared types, codes and segment tables for the charlieplex digit segment sequencer.
// Depends on nothing; imported by the divider, the top level and the checker.
package cpxseg_pkg;

  localparam int VALUE_W     = 16;
  localparam int BASE_W      = 5;
  localparam int DIGIT_W     = 4;
  localparam int SEG_IDX_W   = 6;
  localparam int LIST_W      = 5;
  localparam int COUNT_W     = 5;
  localparam int MAX_RESULTS = 29;
  localparam int MSG0_LEN    = 21;
  localparam int MSG1_LEN    = 10;

  // Operation codes
  localparam logic [2:0] OP_NUMBER  = 3'd0;
  localparam logic [2:0] OP_CHAR    = 3'd1;
  localparam logic [2:0] OP_PAIR    = 3'd2;
  localparam logic [2:0] OP_DECIMAL = 3'd3;
  localparam logic [2:0] OP_BATTERY = 3'd4;
  localparam logic [2:0] OP_MESSAGE = 3'd5;

  // Message ids
  localparam logic [VALUE_W-1:0] MSG_BANNER = 16'd0;
  localparam logic [VALUE_W-1:0] MSG_ERROR  = 16'd1;

  // Special segment indexes and the fixed decimal radix
  localparam logic [SEG_IDX_W-1:0] COLON_IDX   = 6'd28;
  localparam logic [SEG_IDX_W-1:0] POINT_IDX   = 6'd29;
  localparam logic [SEG_IDX_W-1:0] BATTERY_TOP = 6'd37;
  localparam logic [BASE_W-1:0]    DEC_RADIX   = 5'd10;

  typedef struct packed {
    logic [2:0]  operation;
    logic [15:0] primary_value;
    logic [15:0] secondary_value;
    logic [7:0]  right_base;
    logic [7:0]  left_base;
    logic [7:0]  digit_place;
  } req_t;

  typedef struct packed {
    logic [6:0] pin_direction;
    logic [6:0] pin_level;
    logic       last_of_run;
  } res_t;

  // Pin enable and level masks per segment index, packed {direction, level}
  function automatic logic [13:0] seg_rom(input logic [SEG_IDX_W-1:0] idx);
    logic [13:0] v;
    unique case (idx)
      6'd0:    v = {7'h03, 7'h01};
      6'd1:    v = {7'h0C, 7'h04};
      6'd2:    v = {7'h30, 7'h20};
      6'd3:    v = {7'h60, 7'h40};
      6'd4:    v = {7'h03, 7'h02};
      6'd5:    v = {7'h14, 7'h10};
      6'd6:    v = {7'h28, 7'h20};
      6'd7:    v = {7'h50, 7'h40};
      6'd8:    v = {7'h06, 7'h04};
      6'd9:    v = {7'h0C, 7'h08};
      6'd10:   v = {7'h24, 7'h04};
      6'd11:   v = {7'h48, 7'h08};
      6'd12:   v = {7'h0A, 7'h02};
      6'd13:   v = {7'h42, 7'h02};
      6'd14:   v = {7'h22, 7'h20};
      6'd15:   v = {7'h44, 7'h04};
      6'd16:   v = {7'h0A, 7'h08};
      6'd17:   v = {7'h12, 7'h02};
      6'd18:   v = {7'h24, 7'h20};
      6'd19:   v = {7'h48, 7'h40};
      6'd20:   v = {7'h06, 7'h02};
      6'd21:   v = {7'h18, 7'h08};
      6'd22:   v = {7'h30, 7'h10};
      6'd23:   v = {7'h60, 7'h20};
      6'd24:   v = {7'h05, 7'h04};
      6'd25:   v = {7'h14, 7'h04};
      6'd26:   v = {7'h28, 7'h08};
      6'd27:   v = {7'h50, 7'h10};
      6'd28:   v = {7'h18, 7'h10};
      6'd29:   v = {7'h05, 7'h01};
      6'd30:   v = {7'h42, 7'h40};
      6'd31:   v = {7'h22, 7'h02};
      6'd32:   v = {7'h12, 7'h10};
      6'd33:   v = {7'h44, 7'h40};
      6'd34:   v = {7'h11, 7'h01};
      6'd35:   v = {7'h41, 7'h40};
      6'd36:   v = {7'h21, 7'h20};
      6'd37:   v = {7'h09, 7'h08};
      6'd38:   v = {7'h11, 7'h10};
      6'd39:   v = {7'h41, 7'h01};
      6'd40:   v = {7'h21, 7'h01};
      6'd41:   v = {7'h09, 7'h01};
      default: v = '0;
    endcase
    return v;
  endfunction

  // Lit segments of a hex glyph; bit j stands for segment code 4*j
  function automatic logic [6:0] glyph_mask(input logic [DIGIT_W-1:0] d);
    logic [6:0] m;
    unique case (d)
      4'h0: m = 7'b0111111;
      4'h1: m = 7'b0000110;
      4'h2: m = 7'b1011011;
      4'h3: m = 7'b1001111;
      4'h4: m = 7'b1100110;
      4'h5: m = 7'b1101101;
      4'h6: m = 7'b1111101;
      4'h7: m = 7'b0000111;
      4'h8: m = 7'b1111111;
      4'h9: m = 7'b1101111;
      4'hA: m = 7'b1110111;
      4'hB: m = 7'b1111100;
      4'hC: m = 7'b0111001;
      4'hD: m = 7'b1011110;
      4'hE: m = 7'b1111001;
      4'hF: m = 7'b1110001;
      default: m = '0;
    endcase
    return m;
  endfunction

  // Segment list of the fixed banner message
  function automatic logic [SEG_IDX_W-1:0] msg0_seg(input logic [LIST_W-1:0] k);
    logic [SEG_IDX_W-1:0] s;
    unique case (k)
      5'd0:    s = 6'd0;
      5'd1:    s = 6'd2;
      5'd2:    s = 6'd4;
      5'd3:    s = 6'd5;
      5'd4:    s = 6'd6;
      5'd5:    s = 6'd7;
      5'd6:    s = 6'd8;
      5'd7:    s = 6'd9;
      5'd8:    s = 6'd10;
      5'd9:    s = 6'd11;
      5'd10:   s = 6'd14;
      5'd11:   s = 6'd16;
      5'd12:   s = 6'd17;
      5'd13:   s = 6'd18;
      5'd14:   s = 6'd19;
      5'd15:   s = 6'd20;
      5'd16:   s = 6'd21;
      5'd17:   s = 6'd22;
      5'd18:   s = 6'd23;
      5'd19:   s = 6'd24;
      5'd20:   s = 6'd27;
      default: s = '0;
    endcase
    return s;
  endfunction

  // Segment list of the error message
  function automatic logic [SEG_IDX_W-1:0] msg1_seg(input logic [LIST_W-1:0] k);
    logic [SEG_IDX_W-1:0] s;
    unique case (k)
      5'd0:    s = 6'd3;
      5'd1:    s = 6'd15;
      5'd2:    s = 6'd17;
      5'd3:    s = 6'd18;
      5'd4:    s = 6'd19;
      5'd5:    s = 6'd23;
      5'd6:    s = 6'd25;
      5'd7:    s = 6'd26;
      5'd8:    s = 6'd27;
      5'd9:    s = 6'd29;
      default: s = '0;
    endcase
    return s;
  endfunction

  // Position of the lowest set bit of a glyph mask
  function automatic logic [2:0] low_pos(input logic [6:0] m);
    logic [2:0] p;
    p = '0;
    for (int j = 6; j >= 0; j--) begin
      if (m[j]) p = 3'(j);
    end
    return p;
  endfunction

endpackage

// ===== hw/rtl/cpxseg_div.sv =====
// Iterative restoring divider, two quotient bits per cycle, for radix digit extraction.
// Depends on cpxseg_pkg for the value and radix widths.
module cpxseg_div
  import cpxseg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [VALUE_W-1:0] dividend,
  input  logic [BASE_W-1:0]  divisor,
  output logic               done,
  output logic [VALUE_W-1:0] quotient,
  output logic [DIGIT_W-1:0] remainder
);

  localparam int STEPS  = VALUE_W / 2;
  localparam int STEP_W = $clog2(STEPS);

  logic [STEP_W-1:0]  cnt;
  logic               running;
  logic [BASE_W-1:0]  t1, t2;
  logic               ge1, ge2;
  logic [DIGIT_W-1:0] r1, r2;
  logic [VALUE_W-1:0] q1, q2;

  // Two restoring steps: shift in the next dividend bit, subtract when it fits
  always_comb begin
    t1  = {remainder, quotient[VALUE_W-1]};
    ge1 = (t1 >= divisor);
    r1  = ge1 ? DIGIT_W'(t1 - divisor) : t1[DIGIT_W-1:0];
    q1  = {quotient[VALUE_W-2:0], ge1};
    t2  = {r1, q1[VALUE_W-1]};
    ge2 = (t2 >= divisor);
    r2  = ge2 ? DIGIT_W'(t2 - divisor) : t2[DIGIT_W-1:0];
    q2  = {q1[VALUE_W-2:0], ge2};
  end

  // Sequence the steps and pulse done when the quotient is complete
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == STEP_W'(STEPS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Hold the partial remainder and the shifting quotient
  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
    end else if (running) begin
      quotient  <= q2;
      remainder <= r2;
    end
  end

endmodule

// ===== hw/rtl/charlieplex_digit_segment_sequencer_top.sv =====
// Top level of the charlieplex digit segment sequencer: request decode, segment sequencer,
// result register. Depends on cpxseg_pkg and cpxseg_div.

// A request is taken when start is high and busy is low; busy then stays high until the
// final segment of the request is on the result ports, and requests offered meanwhile are
// ignored. Each lit segment comes out as one transaction on result, marked by strobe for
// exactly one cycle; the receiver cannot hold results off, so it must take one segment every
// cycle that strobe is high. The final segment of a request carries last_of_run; a request
// that lights nothing (bad radix, place, level, message id or operation) produces no
// transaction and leaves the block free. Every digit that needs a radix conversion goes
// through one shared divider at two quotient bits per cycle before its lit segments are
// issued one after another; pair and decimal requests end with the colon or point. At
// most 29 segments are issued per request.
module charlieplex_digit_segment_sequencer_top
  import cpxseg_pkg::*;
#(
  parameter int DIGIT_COUNT = 4,
  parameter int MAX_RADIX   = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t request,
  output logic busy,
  output logic strobe,
  output res_t result
);

  localparam int PLACE_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam int HALF    = DIGIT_COUNT / 2;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PREP  = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_GLYPH = 7'b0001000,
    S_LIST  = 7'b0010000,
    S_TAIL  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t                state, state_next, entry_state;
  req_t                  req_q;
  logic [VALUE_W-1:0]    val;
  logic [PLACE_W-1:0]    place;
  logic [6:0]            gmask;
  logic [LIST_W-1:0]     lidx;
  logic [SEG_IDX_W-1:0]  pend_idx;
  logic                  pend_valid;
  logic [COUNT_W-1:0]    count;

  logic                  accept;
  logic                  rb_ok, lb_ok;
  logic                  push_en;
  logic [SEG_IDX_W-1:0]  push_idx;
  logic                  glyph_last, list_last, last_digit;
  logic                  emit_en, emit_last, cap_hit;
  logic [13:0]           rom_word;
  logic [1:0]            level;

  logic                  div_start, div_done, div_switch;
  logic [VALUE_W-1:0]    div_a, div_quo;
  logic [BASE_W-1:0]     div_b;
  logic [DIGIT_W-1:0]    div_rem;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign level  = req_q.primary_value[1:0];

  // Decode the request into its first state; bad operands go nowhere
  always_comb begin
    rb_ok = (int'(request.right_base) >= 2) && (int'(request.right_base) <= MAX_RADIX);
    lb_ok = (int'(request.left_base) >= 2) && (int'(request.left_base) <= MAX_RADIX);
    unique case (request.operation)
      OP_NUMBER:  entry_state = rb_ok ? S_PREP : S_IDLE;
      OP_CHAR:    entry_state = (int'(request.digit_place) < DIGIT_COUNT) ? S_GLYPH : S_IDLE;
      OP_PAIR:    entry_state = (rb_ok && lb_ok) ? S_PREP : S_IDLE;
      OP_DECIMAL: entry_state = S_PREP;
      OP_BATTERY: entry_state = (request.primary_value != 16'd0 &&
                                 request.primary_value <= 16'd3) ? S_LIST : S_IDLE;
      OP_MESSAGE: entry_state = (request.primary_value <= MSG_ERROR) ? S_LIST : S_IDLE;
      default:    entry_state = S_IDLE;
    endcase
  end

  // Pick the dividend and radix for the digit at the current place
  always_comb begin
    div_switch = (req_q.operation == OP_PAIR && int'(place) == HALF) ||
                 (req_q.operation == OP_DECIMAL && int'(place) == 1);
    div_a      = div_switch ? req_q.secondary_value : val;
    if (req_q.operation == OP_DECIMAL) begin
      div_b = DEC_RADIX;
    end else if (req_q.operation == OP_PAIR && int'(place) >= HALF) begin
      div_b = req_q.left_base[BASE_W-1:0];
    end else begin
      div_b = req_q.right_base[BASE_W-1:0];
    end
  end

  cpxseg_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Sequence digits, glyph segments, fixed lists and the trailing mark
  always_comb begin
    state_next = state;
    push_en    = 1'b0;
    push_idx   = '0;
    div_start  = 1'b0;
    glyph_last = ((gmask & (gmask - 7'd1)) == 7'd0);
    last_digit = (int'(place) == DIGIT_COUNT - 1);
    if (req_q.operation == OP_BATTERY) begin
      list_last = (lidx == LIST_W'(level - 2'd1));
    end else if (req_q.primary_value[0]) begin
      list_last = (lidx == LIST_W'(MSG1_LEN - 1));
    end else begin
      list_last = (lidx == LIST_W'(MSG0_LEN - 1));
    end
    unique case (state)
      S_IDLE: begin
        if (start) state_next = entry_state;
      end
      S_PREP: begin
        div_start  = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (div_done) state_next = S_GLYPH;
      end
      S_GLYPH: begin
        push_en  = 1'b1;
        push_idx = {1'b0, low_pos(gmask), 2'b00} + SEG_IDX_W'(place);
        if (glyph_last) begin
          if (req_q.operation == OP_CHAR || req_q.operation == OP_MESSAGE) begin
            state_next = S_DONE;
          end else if (last_digit) begin
            state_next = (req_q.operation == OP_NUMBER) ? S_DONE : S_TAIL;
          end else begin
            state_next = S_PREP;
          end
        end
      end
      S_LIST: begin
        push_en = 1'b1;
        if (req_q.operation == OP_BATTERY) begin
          push_idx = BATTERY_TOP + 6'd1 - {4'd0, level} + {1'b0, lidx};
        end else if (req_q.primary_value[0]) begin
          push_idx = msg1_seg(lidx);
        end else begin
          push_idx = msg0_seg(lidx);
        end
        if (list_last) begin
          state_next = (req_q.operation == OP_MESSAGE && req_q.primary_value[0]) ?
                       S_GLYPH : S_DONE;
        end
      end
      S_TAIL: begin
        push_en    = 1'b1;
        push_idx   = (req_q.operation == OP_PAIR) ? COLON_IDX : POINT_IDX;
        state_next = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    // Drop the rest of the run once the result limit is reached
    cap_hit = push_en && pend_valid && (count == COUNT_W'(MAX_RESULTS - 1));
    if (cap_hit) state_next = S_IDLE;
  end

  // Issue the held segment once the next one is known or the run ends
  always_comb begin
    emit_en   = pend_valid && (push_en || state == S_DONE);
    emit_last = (state == S_DONE) || (count == COUNT_W'(MAX_RESULTS - 1));
    rom_word  = seg_rom(pend_idx);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pend_valid <= 1'b0;
      strobe     <= 1'b0;
      count      <= '0;
    end else begin
      state  <= state_next;
      strobe <= emit_en;
      if (accept) begin
        count <= '0;
      end else if (emit_en) begin
        count <= count + 1'b1;
      end
      if (cap_hit || state == S_DONE) begin
        pend_valid <= 1'b0;
      end else if (push_en) begin
        pend_valid <= 1'b1;
      end
    end
  end

  // Payload: request copy, working value, place, glyph mask, list index, result
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= request;
      val   <= (request.operation == OP_DECIMAL) ?
               {8'd0, request.primary_value[7:0]} : request.primary_value;
      place <= (request.operation == OP_CHAR) ? request.digit_place[PLACE_W-1:0] : '0;
      gmask <= glyph_mask(request.primary_value[DIGIT_W-1:0]);
      lidx  <= '0;
    end else begin
      unique case (state)
        S_DIV: begin
          if (div_done) begin
            val   <= div_quo;
            gmask <= glyph_mask(div_rem);
          end
        end
        S_GLYPH: begin
          gmask <= gmask & (gmask - 7'd1);
          if (glyph_last && !last_digit) place <= place + 1'b1;
        end
        S_LIST: begin
          lidx <= lidx + 1'b1;
          if (list_last) begin
            gmask <= glyph_mask(req_q.secondary_value[DIGIT_W-1:0]);
            place <= '0;
          end
        end
        default: begin
        end
      endcase
    end
    if (push_en) pend_idx <= push_idx;
    if (emit_en) begin
      result.pin_direction <= rom_word[13:7];
      result.pin_level     <= rom_word[6:0];
      result.last_of_run   <= emit_last;
    end
  end

endmodule

// ===== hw/rtl/cpxseg_chk.sv =====
// Port-level checker for the charlieplex digit segment sequencer, bound to the top level.
// Depends on cpxseg_pkg for the result type.
module cpxseg_chk
  import cpxseg_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic busy,
  input logic strobe,
  input res_t result
);

  // Come out of reset idle and quiet
  a_reset_quiet: assert property (@(posedge clk) $fell(rst) |-> !busy && !strobe)
    else $error("busy or strobe set right after reset");

  // Issue a transaction only for work that was in progress
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("result issued without a request in progress");

  // Hold busy while more segments of the run are still to come
  a_run_open: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last_of_run |-> busy)
    else $error("run not closed but block went idle");

  // Close the run: nothing follows the last segment directly
  a_run_closed: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last_of_run |=> !strobe)
    else $error("result issued right after the last segment");

  // Drive exactly one pin pair, with the level bit inside the pair
  a_pin_pair: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $countones(result.pin_direction) == 2 && $onehot(result.pin_level) &&
               ((result.pin_level & ~result.pin_direction) == 7'd0))
    else $error("segment does not drive a single pin pair");

endmodule

bind charlieplex_digit_segment_sequencer_top cpxseg_chk u_cpxseg_chk (.*);
